// ===== design/rfwa_pkg.sv =====
// Package with the shared types and constants of the ranging frame averaging block.
package rfwa_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIST_W = 16;
  // The weighted sum is at most 11 * 65535, which fits in 20 bits.
  localparam int unsigned SUM_W = 20;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hA5;

  // Division by eleven as a multiply by ceil(2^24 / 11) and a right shift by 24.
  // The rounding error of the reciprocal is 6, and 6 * 720885 < 2^24, so the
  // quotient is exact over the whole range of the sum.
  localparam int unsigned RECIP_W = 21;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_11 = 21'd1525202;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [PROD_W-1:0] prod_t;

  // One distance offered by the frame parser to the queue.
  typedef struct packed {
    logic  vld;
    dist_t distance;
  } push_t;

  // Queue status and head entry as seen by the averaging engine.
  typedef struct packed {
    logic  full;
    logic  empty;
    dist_t head;
  } fifo_stat_t;

endpackage

// ===== design/rfwa_ifs.sv =====
// Handshake channel interfaces for the received bytes and the averaged results.
interface rfwa_byte_if import rfwa_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfwa_result_if import rfwa_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t distance;
  dist_t average;

  modport source (output valid, output distance, output average, input ready);
  modport sink (input valid, input distance, input average, output ready);
endinterface

// ===== design/rfwa_frame_parser.sv =====
// Front end: byte-level frame parser that pushes each completed distance into the queue.
module rfwa_frame_parser import rfwa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  byte_t      in_byte,
  output logic       in_ready,
  input  fifo_stat_t fifo_stat,
  output push_t      push
);

  typedef enum logic [1:0] {
    AWAIT_HDR,
    AWAIT_HI,
    AWAIT_LO
  } pos_t;

  pos_t  pos_r;
  byte_t high_r;
  logic  accept;

  // Only the low byte produces a queue entry, so only that byte waits on space.
  assign in_ready = !((pos_r == AWAIT_LO) && fifo_stat.full);
  assign accept   = in_valid && in_ready;

  assign push.vld      = accept && (pos_r == AWAIT_LO);
  assign push.distance = {high_r, in_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= AWAIT_HDR;
      high_r <= '0;
    end else if (accept) begin
      case (pos_r)
        AWAIT_HI: begin
          high_r <= in_byte;
          pos_r  <= AWAIT_LO;
        end
        AWAIT_LO: begin
          pos_r <= AWAIT_HDR;
        end
        default: begin
          // A byte that is not the header is dropped and we stay in sync search.
          pos_r <= (in_byte == HEADER_BYTE) ? AWAIT_HI : AWAIT_HDR;
        end
      endcase
    end
  end

  a_hdr_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (pos_r == AWAIT_HDR) && (in_byte == HEADER_BYTE)) |=> (pos_r == AWAIT_HI))
    else $error("header byte did not start a frame");

endmodule

// ===== design/rfwa_dist_fifo.sv =====
// Short register queue of distances between the frame parser and the averaging engine.
module rfwa_dist_fifo import rfwa_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       pop,
  output fifo_stat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  dist_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.head  = mem_r[rd_ptr_r];

  assign do_push = push.vld && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.distance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> !stat.full)
    else $error("distance pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("distance popped from an empty queue");

endmodule

// ===== design/rfwa_avg_engine.sv =====
// Back end: history shift, weighted sum, and divide-by-eleven pipeline with output register.
module rfwa_avg_engine import rfwa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_stat_t fifo_stat,
  output logic       pop,
  output logic       out_valid,
  output dist_t      out_distance,
  output dist_t      out_average,
  input  logic       out_ready
);

  dist_t hist_r [4];
  logic  a_vld_r;
  sum_t  a_sum_r;
  dist_t a_dist_r;
  logic  b_vld_r;
  dist_t b_dist_r;
  dist_t b_avg_r;
  logic  a_rdy;
  logic  b_rdy;
  sum_t  sum;
  prod_t prod;

  assign b_rdy = !b_vld_r || out_ready;
  assign a_rdy = !a_vld_r || b_rdy;
  assign pop   = a_rdy && !fifo_stat.empty;

  // Weights 1,1,2,3,4 from the oldest stored distance up to the new one.
  assign sum = SUM_W'(hist_r[0]) + SUM_W'(hist_r[1])
             + (SUM_W'(hist_r[2]) << 1)
             + (SUM_W'(hist_r[3]) << 1) + SUM_W'(hist_r[3])
             + (SUM_W'(fifo_stat.head) << 2);

  assign prod = PROD_W'(a_sum_r) * PROD_W'(RECIP_11);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '{default: '0};
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        hist_r[0] <= hist_r[1];
        hist_r[1] <= hist_r[2];
        hist_r[2] <= hist_r[3];
        hist_r[3] <= fifo_stat.head;
        a_vld_r   <= 1'b1;
      end else if (b_rdy) begin
        a_vld_r <= 1'b0;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_sum_r  <= sum;
      a_dist_r <= fifo_stat.head;
    end
    if (a_vld_r && b_rdy) begin
      b_dist_r <= a_dist_r;
      b_avg_r  <= prod[RECIP_SHIFT +: DIST_W];
    end
  end

  assign out_valid    = b_vld_r;
  assign out_distance = b_dist_r;
  assign out_average  = b_avg_r;

  a_stall_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !b_rdy) |=> (a_vld_r && $stable(a_sum_r) && $stable(a_dist_r)))
    else $error("sum stage changed while stalled");

endmodule

// ===== design/ranging_frame_weighted_average_top.sv =====
// Top level of the ranging frame parser with a five-tap weighted moving average.
//
// The block takes bytes of a ranging sensor link on in_ch and finds frames
// made of a 0xA5 header, a distance high byte and a
// distance low byte. A byte that is not 0xA5 where a header is expected is
// dropped; inside a frame every byte is data, 0xA5 included. Each complete
// frame yields one transfer on out_ch carrying the 16-bit distance and the
// weighted average (h0 + h1 + 2*h2 + 3*h3 + 4*distance) / 11, truncated, where
// h0..h3 are the four previous distances, oldest first, all zero after reset.
// The byte input takes one transfer per cycle, except that a low byte waits
// while the distance queue is full. A result passes through the distance
// queue, the weighted-sum register and then the output register, which
// holds the reciprocal multiply that stands in for the divide.
// Header and high bytes are always taken; a low byte waits only while the
// distance queue is full, which happens only while out_ch is held off, so
// FIFO_DEPTH sets how many finished frames the block absorbs under backpressure
// on top of the two in the pipeline. Synchronous active-low reset on rst_n.
module ranging_frame_weighted_average_top import rfwa_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  rfwa_byte_if.sink   in_ch,
  rfwa_result_if.source out_ch
);

  push_t      push;
  fifo_stat_t fifo_stat;
  logic       pop;

  // Front end: frame synchronization and distance assembly.
  rfwa_frame_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.rx_byte),
    .in_ready  (in_ch.ready),
    .fifo_stat (fifo_stat),
    .push      (push)
  );

  // Decouples the parser from the averaging pipeline so each can stall alone.
  rfwa_dist_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (fifo_stat)
  );

  // Back end: history update, weighted sum and the divide by eleven.
  rfwa_avg_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_stat    (fifo_stat),
    .pop          (pop),
    .out_valid    (out_ch.valid),
    .out_distance (out_ch.distance),
    .out_average  (out_ch.average),
    .out_ready    (out_ch.ready)
  );

endmodule
